FILE: hw/rtl/ods_pkg.sv
package ods_pkg;

    localparam int STREAMS_DEF = 16;
    localparam int STREAMS_MAX = 16;

    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int PERIOD_W   = 16;
    localparam int AGE_W      = 16;
    localparam int SHOWN_W    = 17;
    localparam int SUM_W      = 32;
    localparam int TIME_W     = 32;
    localparam int NUM_W      = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic scan;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] n_in_use;
    } dp_status_t;

endpackage

FILE: hw/rtl/ods_datapath.sv
module ods_datapath #(
    parameter int STREAMS = ods_pkg::STREAMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [ods_pkg::CNT_W-1:0]         cfg_wdata,
    input  ods_pkg::dp_cmd_t                  cmd,
    input  logic [((STREAMS < ods_pkg::STREAMS_MAX ? STREAMS : ods_pkg::STREAMS_MAX) > 1
                   ? $clog2(STREAMS < ods_pkg::STREAMS_MAX ? STREAMS : ods_pkg::STREAMS_MAX)
                   : 1)-1:0]                  idx,
    input  logic [ods_pkg::IN_DATA_W-1:0]     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ods_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                              out_last,
    output ods_pkg::dp_status_t               status
);

    localparam int DEPTH = (STREAMS < ods_pkg::STREAMS_MAX) ? STREAMS : ods_pkg::STREAMS_MAX;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = ods_pkg::CNT_W;
    localparam int AW    = ods_pkg::AGE_W;
    localparam int SW    = ods_pkg::SUM_W;
    localparam int TW    = ods_pkg::TIME_W;
    localparam int PW    = ods_pkg::PERIOD_W;

    logic [CW-1:0] count_reg;
    logic [PW-1:0] period_reg [DEPTH];
    logic [PW-1:0] phase_reg  [DEPTH];
    logic [AW-1:0] age_reg    [DEPTH];
    logic [SW-1:0] sum_reg    [DEPTH];
    logic [TW-1:0] time_reg;
    logic          have_reg;
    logic [IW-1:0] best_reg;
    logic [AW-1:0] best_age_reg;
    logic          out_valid_reg;
    logic          out_last_reg;
    logic [ods_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [ods_pkg::IDX_W-1:0] load_idx;
    logic [PW-1:0]             load_period;
    logic [IW-1:0]             load_addr;
    logic                      load_hit;
    logic [CW-1:0]             n_in_use;
    logic [PW-1:0]             period_cur;
    logic [PW:0]               phase_inc;
    logic                      due;
    logic                      in_use;
    logic                      better;
    logic [AW-1:0]             age_cur;
    logic [AW-1:0]             age_inc;
    logic                      pick;
    logic [SW:0]               sum_add;
    logic [SW-1:0]             sum_out;
    logic [ods_pkg::SHOWN_W-1:0] shown_age;
    logic [ods_pkg::NUM_W-1:0] stream_number;
    logic                      is_last;

    assign load_idx    = in_data[ods_pkg::IDX_W-1:0];
    assign load_period = in_data[ods_pkg::IDX_W +: PW];
    assign load_addr   = load_idx[IW-1:0];
    assign load_hit    = cmd.load && (load_period != '0)
                         && ({1'b0, load_idx} < CW'(DEPTH));

    assign n_in_use   = (count_reg > CW'(DEPTH)) ? CW'(DEPTH) : count_reg;

    assign period_cur = period_reg[idx];
    assign phase_inc  = {1'b0, phase_reg[idx]} + (PW+1)'(1);
    assign due        = (period_cur != '0) && (phase_inc >= {1'b0, period_cur});
    assign in_use     = CW'(idx) < n_in_use;
    assign age_cur    = age_reg[idx];
    assign better     = due && in_use && (!have_reg || (age_cur > best_age_reg));

    assign pick          = have_reg && (best_reg == idx);
    assign age_inc       = (age_cur == '1) ? age_cur : age_cur + AW'(1);
    assign sum_add       = {1'b0, sum_reg[idx]} + (SW+1)'(age_inc);
    assign sum_out       = pick ? sum_reg[idx] : (sum_add[SW] ? '1 : sum_add[SW-1:0]);
    assign shown_age     = {1'b0, age_cur} + ods_pkg::SHOWN_W'(1);
    assign stream_number = ods_pkg::NUM_W'(idx) + ods_pkg::NUM_W'(1);
    assign is_last       = (CW'(idx) + CW'(1)) == n_in_use;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CW'(1);
            time_reg      <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                phase_reg[i] <= '0;
                age_reg[i]   <= '0;
                sum_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                count_reg <= cfg_wdata;
            end
            if (load_hit)
            begin
                phase_reg[load_addr] <= '0;
                age_reg[load_addr]   <= '0;
                sum_reg[load_addr]   <= '0;
            end
            if (cmd.tick_start)
            begin
                have_reg <= 1'b0;
                if (time_reg != '1)
                begin
                    time_reg <= time_reg + TW'(1);
                end
            end
            if (cmd.scan)
            begin
                if (period_cur != '0)
                begin
                    phase_reg[idx] <= due ? '0 : phase_inc[PW-1:0];
                end
                if (better)
                begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                age_reg[idx]  <= pick ? '0 : age_inc;
                sum_reg[idx]  <= sum_out;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            period_reg[load_addr] <= load_period;
        end
        if (cmd.scan && better)
        begin
            best_reg     <= idx;
            best_age_reg <= age_cur;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {1'b0, time_reg, sum_out, pick, shown_age, stream_number};
            out_last_reg <= is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_last        = out_last_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.n_in_use = n_in_use;

endmodule

FILE: hw/rtl/ods_controller.sv
module ods_controller #(
    parameter int STREAMS = ods_pkg::STREAMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_kind,
    input  ods_pkg::dp_status_t status,
    output ods_pkg::dp_cmd_t    cmd,
    output logic [((STREAMS < ods_pkg::STREAMS_MAX ? STREAMS : ods_pkg::STREAMS_MAX) > 1
                   ? $clog2(STREAMS < ods_pkg::STREAMS_MAX ? STREAMS : ods_pkg::STREAMS_MAX)
                   : 1)-1:0]    idx
);

    localparam int DEPTH = (STREAMS < ods_pkg::STREAMS_MAX) ? STREAMS : ods_pkg::STREAMS_MAX;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = ods_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [IW-1:0] cnt_reg;
    logic [IW-1:0] cnt_next;
    logic          accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign cmd.load       = accept && (in_kind == ods_pkg::CMD_LOAD);
    assign cmd.tick_start = accept && (in_kind == ods_pkg::CMD_TICK);
    assign cmd.scan       = (state_reg == ST_SCAN);
    assign cmd.emit       = (state_reg == ST_EMIT) && status.out_free;
    assign idx            = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.tick_start)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == IW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = (status.n_in_use == '0) ? ST_IDLE : ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if ((CW'(cnt_reg) + CW'(1)) == status.n_in_use)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/oldest_due_stream_scheduler_top.sv
// Load request: taken while idle, no result.
// Tick request: a scan of every stored stream (min(STREAMS,16)), one per cycle, then one result
// per stream in use per cycle while taken.
// The scan and emit sequencer walks the per-stream registers in stream order.
// Reset (rst_n, async, active low) clears ages, sums, phases, time and sets count to 1.
module oldest_due_stream_scheduler_top #(
    parameter int STREAMS = ods_pkg::STREAMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [ods_pkg::CNT_W-1:0]         cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] stream_index, [19:4] period_value, [23:20] zero
    input  logic [ods_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] command
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [4:0] stream_number, [21:5] shown_age, [22] chosen, [54:23] age_total,
    // [86:55] tick_number, [87] zero
    output logic [ods_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int DEPTH = (STREAMS < ods_pkg::STREAMS_MAX) ? STREAMS : ods_pkg::STREAMS_MAX;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ods_pkg::dp_cmd_t    cmd;
    ods_pkg::dp_status_t status;
    logic [IW-1:0]       idx;

    ods_controller #(
        .STREAMS (STREAMS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser),
        .status   (status),
        .cmd      (cmd),
        .idx      (idx)
    );

    ods_datapath #(
        .STREAMS (STREAMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .idx       (idx),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .status    (status)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ods_pkg::CMD_TICK))
        |=> !s_axis_tready)
        else $error("request taken during tick processing");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] != '0))
        else $error("stream number out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && s_axis_tready)
        |-> (m_axis_tdata[4:0] == status.n_in_use))
        else $error("last flag not on final stream in use");
`endif

endmodule

FILE: tb/oldest_due_stream_scheduler_top_tb.sv
`timescale 1ns / 100ps

module oldest_due_stream_scheduler_top_tb;

    localparam int NSTREAMS      = ods_pkg::STREAMS_DEF;
    localparam int SETTLE_CYCLES = 70;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [ods_pkg::NUM_W-1:0]   stream_number;
        logic [ods_pkg::SHOWN_W-1:0] shown_age;
        logic                        chosen;
        logic [ods_pkg::SUM_W-1:0]   age_total;
        logic [ods_pkg::TIME_W-1:0]  tick_number;
        logic                        last;
    } stream_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wen = 1'b0;
    logic [ods_pkg::CNT_W-1:0]      cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ods_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = ods_pkg::CMD_LOAD;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ods_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    // scheduler image kept by the testbench
    logic [ods_pkg::PERIOD_W-1:0] period_of [NSTREAMS];
    logic [ods_pkg::PERIOD_W-1:0] phase_of  [NSTREAMS];
    logic [ods_pkg::AGE_W-1:0]    age_of    [NSTREAMS];
    logic [ods_pkg::SUM_W-1:0]    sum_of    [NSTREAMS];
    logic [ods_pkg::TIME_W-1:0]   now_tick;
    logic [ods_pkg::CNT_W-1:0]    active_count;

    stream_report_t report_q [$];
    stream_report_t seen_report;
    stream_report_t due_report;

    int error_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    oldest_due_stream_scheduler_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic reset_schedule();
        int i;
        for (i = 0; i < NSTREAMS; i++)
        begin
            period_of[i] = '0;
            phase_of[i]  = '0;
            age_of[i]    = '0;
            sum_of[i]    = '0;
        end
        now_tick     = '0;
        active_count = ods_pkg::CNT_W'(1);
    endtask

    task automatic apply_request(input logic cmd, input logic [ods_pkg::IDX_W-1:0] idx,
                                 input logic [ods_pkg::PERIOD_W-1:0] per);
        int i;
        int lim;
        int n;
        int best;
        int ph;
        bit have;
        bit due_now [NSTREAMS];
        logic [ods_pkg::AGE_W-1:0] a;
        logic [ods_pkg::SUM_W:0] s;
        stream_report_t rep;
        if (cmd == ods_pkg::CMD_LOAD)
        begin
            if (per != '0 && int'(idx) < NSTREAMS)
            begin
                period_of[idx] = per;
                phase_of[idx]  = '0;
                age_of[idx]    = '0;
                sum_of[idx]    = '0;
            end
        end
        else
        begin
            if (now_tick != '1)
                now_tick = now_tick + 1;
            for (i = 0; i < NSTREAMS; i++)
            begin
                due_now[i] = 1'b0;
                if (period_of[i] != '0)
                begin
                    ph = int'(phase_of[i]) + 1;
                    if (ph >= int'(period_of[i]))
                    begin
                        due_now[i] = 1'b1;
                        ph = 0;
                    end
                    phase_of[i] = ph[ods_pkg::PERIOD_W-1:0];
                end
            end
            lim = (NSTREAMS < 16) ? NSTREAMS : 16;
            n = (int'(active_count) > lim) ? lim : int'(active_count);
            best = 0;
            have = 1'b0;
            for (i = 0; i < n; i++)
            begin
                if (due_now[i] && (!have || age_of[i] > age_of[best]))
                begin
                    best = i;
                    have = 1'b1;
                end
            end
            for (i = 0; i < n; i++)
            begin
                rep.stream_number = ods_pkg::NUM_W'(i + 1);
                rep.shown_age     = {1'b0, age_of[i]} + 1'b1;
                rep.chosen        = have && (i == best);
                if (rep.chosen)
                    age_of[i] = '0;
                else
                begin
                    a = age_of[i];
                    if (a != '1)
                        a = a + 1'b1;
                    age_of[i] = a;
                    s = {1'b0, sum_of[i]} + a;
                    sum_of[i] = s[ods_pkg::SUM_W] ? '1 : s[ods_pkg::SUM_W-1:0];
                end
                rep.age_total   = sum_of[i];
                rep.tick_number = now_tick;
                rep.last        = (i + 1 == n);
                report_q.push_back(rep);
            end
        end
    endtask

    task automatic send_request(input logic cmd, input logic [ods_pkg::IDX_W-1:0] idx,
                                input logic [ods_pkg::PERIOD_W-1:0] per);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, per, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(cmd, idx, per);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stream_count(input logic [ods_pkg::CNT_W-1:0] value);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        active_count = value;
    endtask

    task automatic send_random_traffic(input int items);
        int k;
        int r;
        logic [ods_pkg::IDX_W-1:0] idx;
        logic [ods_pkg::PERIOD_W-1:0] per;
        for (k = 0; k < items; k++)
        begin
            r   = int'($urandom_range(99));
            idx = ods_pkg::IDX_W'($urandom_range(15));
            per = ods_pkg::PERIOD_W'($urandom_range(65535));
            if (r < 78)
                send_request(ods_pkg::CMD_TICK, idx, per);
            else if (r < 93)
                send_request(ods_pkg::CMD_LOAD, idx, ods_pkg::PERIOD_W'($urandom_range(12, 1)));
            else if (r < 97)
                send_request(ods_pkg::CMD_LOAD, idx, per);
            else
                send_request(ods_pkg::CMD_LOAD, idx, '0);
        end
    endtask

    // every period is loaded before the first tick
    task automatic test_load_periods();
        int i;
        logic [ods_pkg::PERIOD_W-1:0] pers [16];
        pers = '{16'd2, 16'd1, 16'd1, 16'd3, 16'hFFFF, 16'd4, 16'd5, 16'd6,
                 16'd7, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'h5555, 16'h8000};
        for (i = 0; i < 16; i++)
            send_request(ods_pkg::CMD_LOAD, ods_pkg::IDX_W'(i), pers[i]);
        send_request(ods_pkg::CMD_LOAD, 4'd6, '0);
    endtask

    task automatic test_default_count();
        send_request(ods_pkg::CMD_TICK, 4'hF, 16'hFFFF);
        send_request(ods_pkg::CMD_TICK, 4'h0, 16'h0000);
    endtask

    task automatic test_count_extremes();
        write_stream_count(5'd16);
        send_request(ods_pkg::CMD_TICK, 4'h5, 16'hAAAA);
        write_stream_count(5'd0);
        send_request(ods_pkg::CMD_TICK, 4'hA, 16'h5555);
        write_stream_count(5'd31);
        send_request(ods_pkg::CMD_TICK, 4'h0, 16'h0001);
        write_stream_count(5'd17);
        send_request(ods_pkg::CMD_TICK, 4'h3, 16'h1234);
    endtask

    task automatic test_late_reload();
        send_request(ods_pkg::CMD_LOAD, 4'd0, 16'd3);
        send_request(ods_pkg::CMD_TICK, 4'd0, 16'd0);
        send_request(ods_pkg::CMD_TICK, 4'd0, 16'd0);
        send_request(ods_pkg::CMD_TICK, 4'd0, 16'd0);
    endtask

    task automatic test_random_phases();
        write_stream_count(5'd16);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random_traffic(100);
        write_stream_count(ods_pkg::CNT_W'($urandom_range(16, 1)));
        tx_idle_pct  = 55;
        rx_stall_pct = 0;
        send_random_traffic(100);
        write_stream_count(ods_pkg::CNT_W'($urandom_range(31)));
        tx_idle_pct  = 0;
        rx_stall_pct = 55;
        send_random_traffic(100);
        write_stream_count(5'd16);
        tx_idle_pct  = 10;
        rx_stall_pct = 10;
        send_random_traffic(100);
    endtask

    // hold the receiver off while requests keep coming
    task automatic test_receiver_backpressure();
        write_stream_count(5'd16);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_requests++;
        send_random_traffic(40);
    endtask

    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_report.stream_number = m_axis_tdata[4:0];
            seen_report.shown_age     = m_axis_tdata[21:5];
            seen_report.chosen        = m_axis_tdata[22];
            seen_report.age_total     = m_axis_tdata[54:23];
            seen_report.tick_number   = m_axis_tdata[86:55];
            seen_report.last          = m_axis_tlast;
            if (report_q.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got stream %0d tick %0d",
                         $time, seen_report.stream_number, seen_report.tick_number);
                error_count++;
            end
            else
            begin
                due_report = report_q.pop_front();
                check_field("stream_number", due_report.stream_number,
                            seen_report.stream_number);
                check_field("shown_age", due_report.shown_age, seen_report.shown_age);
                check_field("chosen", due_report.chosen, seen_report.chosen);
                check_field("age_total", due_report.age_total, seen_report.age_total);
                check_field("tick_number", due_report.tick_number, seen_report.tick_number);
                check_field("last", due_report.last, seen_report.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t ns: no request or result accepted for %0d cycles",
                         $time, QUIET_LIMIT);
                $display("** oldest_due_stream_scheduler_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        reset_schedule();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_periods();
        test_default_count();
        test_count_extremes();
        test_late_reload();
        test_random_phases();
        test_receiver_backpressure();
        wait_idle();
        if (error_count == 0)
            $display("** oldest_due_stream_scheduler_top: PASSED **");
        else
            $display("** oldest_due_stream_scheduler_top: FAILED **");
        $finish;
    end

endmodule
